// ===== rtl/usbcrh_pkg.sv =====
// Shared types and constants of the USB control request handler.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none

package usbcrh_pkg;

    localparam int NUM_DESC = 6;
    localparam int CFG_INDEX_W = 3;

    localparam logic [1:0] OP_BUS_RESET = 2'd0;
    localparam logic [1:0] OP_SOF       = 2'd1;
    localparam logic [1:0] OP_SETUP     = 2'd2;

    localparam logic [1:0] LINK_NOT_READY = 2'd0;
    localparam logic [1:0] LINK_READY     = 2'd1;
    localparam logic [1:0] LINK_ERROR     = 2'd2;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_ACK   = 3'd1;
    localparam logic [2:0] ACT_SEND  = 3'd2;
    localparam logic [2:0] ACT_STALL = 3'd3;
    localparam logic [2:0] ACT_ADDR  = 3'd4;
    localparam logic [2:0] ACT_LINE  = 3'd5;

    localparam logic [2:0] DSEL_DEVICE  = 3'd0;
    localparam logic [2:0] DSEL_CONFIG  = 3'd1;
    localparam logic [2:0] DSEL_LANG    = 3'd2;
    localparam logic [2:0] DSEL_MFR     = 3'd3;
    localparam logic [2:0] DSEL_PRODUCT = 3'd4;
    localparam logic [2:0] DSEL_SERIAL  = 3'd5;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEVICE_LEN  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONFIG_LEN  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LANG_LEN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MFR_LEN     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRODUCT_LEN = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SERIAL_LEN  = 3'd5;

    localparam logic [7:0] RST_DEVICE_LEN  = 8'h12;
    localparam logic [7:0] RST_CONFIG_LEN  = 8'h43;
    localparam logic [7:0] RST_LANG_LEN    = 8'd4;
    localparam logic [7:0] RST_MFR_LEN     = 8'h20;
    localparam logic [7:0] RST_PRODUCT_LEN = 8'd24;
    localparam logic [7:0] RST_SERIAL_LEN  = 8'd10;

    localparam logic [1:0] REQ_KIND_STANDARD = 2'd0;
    localparam logic [1:0] REQ_KIND_CLASS    = 2'd1;
    localparam logic [4:0] RECIP_DEVICE      = 5'd0;
    localparam logic [4:0] RECIP_INTERFACE   = 5'd1;

    localparam logic [7:0] REQ_SET_ADDR        = 8'd5;
    localparam logic [7:0] REQ_GET_DESC        = 8'd6;
    localparam logic [7:0] REQ_SET_CONFIG      = 8'd9;
    localparam logic [7:0] REQ_SET_LINE_CODING = 8'd32;
    localparam logic [7:0] REQ_SET_CTRL_LINE   = 8'd34;

    localparam logic [7:0] DT_DEVICE    = 8'd1;
    localparam logic [7:0] DT_CONFIG    = 8'd2;
    localparam logic [7:0] DT_STRING    = 8'd3;
    localparam logic [7:0] DT_QUALIFIER = 8'd6;

    localparam logic [15:0] LINE_CODING_LEN = 16'd7;
    localparam logic [6:0]  ADDR_MASK       = 7'h7f;
    localparam logic [3:0]  PACKET_COUNT_MAX = 4'd15;

    typedef logic [NUM_DESC-1:0][7:0] desc_len_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_length;
    } item_t;

    typedef struct packed {
        logic [1:0]  link_mode;
        logic [6:0]  addr;
        logic        addr_en;
        logic [31:0] sof;
    } link_t;

    typedef struct packed {
        logic [2:0] action;
        logic [2:0] descriptor_sel;
        logic [7:0] transfer_length;
        logic [3:0] packet_count;
    } reply_t;

endpackage

`default_nettype wire

// ===== rtl/usb_control_request_handler_core.sv =====
// Top level of the USB control request handler: input register, decision, result register.
// Depends on usbcrh_pkg, usbcrh_cfg_regs and usbcrh_decode.
// An accepted event beat is held in the input register, then its result is held in the result register.
// Throughput: one event per cycle; the input and result registers stall only on out_ready.
// The decision, the state update and the packet count are combinational between the two registers.
// Reset: link not ready, address zero and disabled, frame count zero, descriptor lengths default.
`default_nettype none

module usb_control_request_handler_core #(
    parameter int PACKET_BYTES = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         op,
    input  wire logic [7:0]                         request_type,
    input  wire logic [7:0]                         request_code,
    input  wire logic [15:0]                        request_value,
    input  wire logic [15:0]                        request_length,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [2:0]                              action,
    output logic [2:0]                              descriptor_sel,
    output logic [7:0]                              transfer_length,
    output logic [3:0]                              packet_count,
    output logic [6:0]                              device_address,
    output logic                                    address_enabled,
    output logic [1:0]                              link_state,
    output logic [31:0]                             frame_count,
    input  wire logic                               cfg_we,
    input  wire logic [usbcrh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data
);

    usbcrh_pkg::desc_len_t desc_len;
    usbcrh_pkg::item_t     item_reg;
    logic                  item_valid_reg;
    usbcrh_pkg::link_t     link_reg;
    usbcrh_pkg::link_t     link_next;
    usbcrh_pkg::reply_t    reply_next;
    usbcrh_pkg::reply_t    reply_reg;
    usbcrh_pkg::link_t     out_link_reg;
    logic                  out_valid_reg;
    logic                  out_free;
    logic                  advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = item_valid_reg && out_free;
    assign in_ready = !item_valid_reg || out_free;

    usbcrh_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .desc_len  (desc_len)
    );

    usbcrh_decode #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_decode (
        .item      (item_reg),
        .link      (link_reg),
        .desc_len  (desc_len),
        .link_next (link_next),
        .reply     (reply_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (in_ready)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.op             <= op;
            item_reg.request_type   <= request_type;
            item_reg.request_code   <= request_code;
            item_reg.request_value  <= request_value;
            item_reg.request_length <= request_length;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_reg.link_mode <= usbcrh_pkg::LINK_NOT_READY;
            link_reg.addr      <= '0;
            link_reg.addr_en   <= 1'b0;
            link_reg.sof       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
                link_reg <= link_next;
            if (out_free)
                out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            reply_reg    <= reply_next;
            out_link_reg <= link_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign action          = reply_reg.action;
    assign descriptor_sel  = reply_reg.descriptor_sel;
    assign transfer_length = reply_reg.transfer_length;
    assign packet_count    = reply_reg.packet_count;
    assign device_address  = out_link_reg.addr;
    assign address_enabled = out_link_reg.addr_en;
    assign link_state      = out_link_reg.link_mode;
    assign frame_count     = out_link_reg.sof;

    a_error_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.op == usbcrh_pkg::OP_SETUP &&
        link_reg.link_mode == usbcrh_pkg::LINK_ERROR
        |=> action == usbcrh_pkg::ACT_STALL && link_state == usbcrh_pkg::LINK_ERROR)
        else $error("setup in error state was not stalled");

    a_bus_reset: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.op == usbcrh_pkg::OP_BUS_RESET
        |=> device_address == 7'd0 && !address_enabled &&
            link_state == usbcrh_pkg::LINK_NOT_READY && action == usbcrh_pkg::ACT_NONE)
        else $error("bus reset did not return to default state");

    a_sof_count: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.op == usbcrh_pkg::OP_SOF
        |=> frame_count == $past(link_reg.sof) + 32'd1)
        else $error("frame count did not advance on start of frame");

    a_send_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != usbcrh_pkg::ACT_SEND
        |-> descriptor_sel == 3'd0 && transfer_length == 8'd0 && packet_count == 4'd0)
        else $error("descriptor fields set without a descriptor send");

    a_send_packets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action == usbcrh_pkg::ACT_SEND
        |-> packet_count != 4'd0 && descriptor_sel <= usbcrh_pkg::DSEL_SERIAL)
        else $error("descriptor send with bad selection or packet count");

endmodule

`default_nettype wire

// ===== rtl/usbcrh_cfg_regs.sv =====
// Descriptor length registers of the USB control request handler.
// Depends on usbcrh_pkg for the register indexes and reset values.
`default_nettype none

module usbcrh_cfg_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [usbcrh_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                         cfg_data,
    output usbcrh_pkg::desc_len_t                   desc_len
);

    usbcrh_pkg::desc_len_t len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg[0] <= usbcrh_pkg::RST_DEVICE_LEN;
            len_reg[1] <= usbcrh_pkg::RST_CONFIG_LEN;
            len_reg[2] <= usbcrh_pkg::RST_LANG_LEN;
            len_reg[3] <= usbcrh_pkg::RST_MFR_LEN;
            len_reg[4] <= usbcrh_pkg::RST_PRODUCT_LEN;
            len_reg[5] <= usbcrh_pkg::RST_SERIAL_LEN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                usbcrh_pkg::CFG_DEVICE_LEN:  len_reg[0] <= cfg_data;
                usbcrh_pkg::CFG_CONFIG_LEN:  len_reg[1] <= cfg_data;
                usbcrh_pkg::CFG_LANG_LEN:    len_reg[2] <= cfg_data;
                usbcrh_pkg::CFG_MFR_LEN:     len_reg[3] <= cfg_data;
                usbcrh_pkg::CFG_PRODUCT_LEN: len_reg[4] <= cfg_data;
                usbcrh_pkg::CFG_SERIAL_LEN:  len_reg[5] <= cfg_data;
                default:                     len_reg <= len_reg;
            endcase
        end
    end

    assign desc_len = len_reg;

endmodule

`default_nettype wire

// ===== rtl/usbcrh_decode.sv =====
// Request decision logic: next link state and reply for one event.
// Depends on usbcrh_pkg; purely combinational.
`default_nettype none

module usbcrh_decode #(
    parameter int PACKET_BYTES = 32
) (
    input  wire usbcrh_pkg::item_t     item,
    input  wire usbcrh_pkg::link_t     link,
    input  wire usbcrh_pkg::desc_len_t desc_len,
    output usbcrh_pkg::link_t          link_next,
    output usbcrh_pkg::reply_t         reply
);

    // Ceiling reciprocal; exact quotient for all 8-bit lengths and packet sizes up to 64.
    localparam logic [16:0] RECIP = 17'(((1 << 16) + PACKET_BYTES - 1) / PACKET_BYTES);

    logic [1:0]  kind;
    logic [4:0]  recip;
    logic [7:0]  dtype;
    logic [7:0]  didx;
    logic        send;
    logic [2:0]  sel;
    logic [7:0]  tbl_len;
    logic [7:0]  tlen;
    logic [24:0] prod;
    logic [7:0]  quot;
    logic [3:0]  pkts;

    assign kind  = item.request_type[6:5];
    assign recip = item.request_type[4:0];
    assign dtype = item.request_value[15:8];
    assign didx  = item.request_value[7:0];

    always_comb
    begin
        link_next = link;
        send      = 1'b0;
        sel       = usbcrh_pkg::DSEL_DEVICE;
        reply     = '0;
        case (item.op)
            usbcrh_pkg::OP_BUS_RESET:
            begin
                link_next.link_mode = usbcrh_pkg::LINK_NOT_READY;
                link_next.addr      = '0;
                link_next.addr_en   = 1'b0;
            end
            usbcrh_pkg::OP_SOF:
            begin
                link_next.sof = link.sof + 32'd1;
            end
            usbcrh_pkg::OP_SETUP:
            begin
                reply.action = usbcrh_pkg::ACT_STALL;
                if (link.link_mode == usbcrh_pkg::LINK_ERROR)
                begin
                    reply.action = usbcrh_pkg::ACT_STALL;
                end
                else if (kind == usbcrh_pkg::REQ_KIND_STANDARD &&
                         recip == usbcrh_pkg::RECIP_DEVICE)
                begin
                    case (item.request_code)
                        usbcrh_pkg::REQ_SET_ADDR:
                        begin
                            link_next.addr    = item.request_value[6:0] & usbcrh_pkg::ADDR_MASK;
                            link_next.addr_en = 1'b1;
                            reply.action      = usbcrh_pkg::ACT_ADDR;
                        end
                        usbcrh_pkg::REQ_GET_DESC:
                        begin
                            case (dtype)
                                usbcrh_pkg::DT_DEVICE:
                                begin
                                    send = 1'b1;
                                    sel  = usbcrh_pkg::DSEL_DEVICE;
                                end
                                usbcrh_pkg::DT_CONFIG:
                                begin
                                    send = 1'b1;
                                    sel  = usbcrh_pkg::DSEL_CONFIG;
                                end
                                usbcrh_pkg::DT_STRING:
                                begin
                                    send = 1'b1;
                                    if (didx inside {[8'd1:8'd3]})
                                        sel = 3'(didx + 8'd2);
                                    else
                                        sel = usbcrh_pkg::DSEL_LANG;
                                end
                                usbcrh_pkg::DT_QUALIFIER:
                                begin
                                    reply.action = usbcrh_pkg::ACT_STALL;
                                end
                                default:
                                begin
                                    link_next.link_mode = usbcrh_pkg::LINK_ERROR;
                                end
                            endcase
                        end
                        usbcrh_pkg::REQ_SET_CONFIG:
                        begin
                            reply.action = usbcrh_pkg::ACT_ACK;
                        end
                        default:
                        begin
                            link_next.link_mode = usbcrh_pkg::LINK_ERROR;
                        end
                    endcase
                end
                else if (kind == usbcrh_pkg::REQ_KIND_CLASS &&
                         recip == usbcrh_pkg::RECIP_INTERFACE &&
                         item.request_code == usbcrh_pkg::REQ_SET_LINE_CODING)
                begin
                    if (item.request_length == usbcrh_pkg::LINE_CODING_LEN)
                        reply.action = usbcrh_pkg::ACT_LINE;
                    else
                        link_next.link_mode = usbcrh_pkg::LINK_ERROR;
                end
                else if (kind == usbcrh_pkg::REQ_KIND_CLASS &&
                         recip == usbcrh_pkg::RECIP_INTERFACE &&
                         item.request_code == usbcrh_pkg::REQ_SET_CTRL_LINE)
                begin
                    link_next.link_mode = usbcrh_pkg::LINK_READY;
                    reply.action        = usbcrh_pkg::ACT_ACK;
                end
                else
                begin
                    link_next.link_mode = usbcrh_pkg::LINK_ERROR;
                end
            end
            default:
            begin
                reply.action = usbcrh_pkg::ACT_NONE;
            end
        endcase
        if (send)
        begin
            reply.action          = usbcrh_pkg::ACT_SEND;
            reply.descriptor_sel  = sel;
            reply.transfer_length = tlen;
            reply.packet_count    = pkts;
        end
    end

    always_comb
    begin
        case (sel)
            usbcrh_pkg::DSEL_DEVICE:  tbl_len = desc_len[0];
            usbcrh_pkg::DSEL_CONFIG:  tbl_len = desc_len[1];
            usbcrh_pkg::DSEL_LANG:    tbl_len = desc_len[2];
            usbcrh_pkg::DSEL_MFR:     tbl_len = desc_len[3];
            usbcrh_pkg::DSEL_PRODUCT: tbl_len = desc_len[4];
            usbcrh_pkg::DSEL_SERIAL:  tbl_len = desc_len[5];
            default:                  tbl_len = desc_len[0];
        endcase
    end

    assign tlen = (item.request_length < {8'd0, tbl_len}) ? item.request_length[7:0] : tbl_len;
    assign prod = 25'(tlen) * 25'(RECIP);
    assign quot = prod[23:16];
    assign pkts = (quot >= 8'(usbcrh_pkg::PACKET_COUNT_MAX)) ? usbcrh_pkg::PACKET_COUNT_MAX
                                                              : 4'(quot + 8'd1);

endmodule

`default_nettype wire
